>>> rtl/core/lki_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lki_pkg;

    // Table size and the widths that follow from it.
    localparam int MAX_KEYS = 16;
    localparam int IDX_W    = $clog2(MAX_KEYS);
    localparam int KCNT_W   = $clog2(MAX_KEYS + 1);

    // Fixed field widths.
    localparam int TIME_W   = 20;
    localparam int OFF_W    = 16;
    localparam int SLOT_W   = 4;
    localparam int QTIME_W  = 32;
    localparam int KCFG_W   = 5;
    localparam int SEG_W    = 4;
    localparam int OUTC_W   = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Shared restoring divider: numerator, divisor, product and quotient widths.
    localparam int DIV_W   = 36;
    localparam int DVS_W   = TIME_W;
    localparam int CNT_W   = $clog2(DIV_W);
    localparam int PROD_W  = TIME_W + OFF_W + 2;
    localparam int QUO_W   = OFF_W + 1;

    // Item modes.
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Result outcome codes.
    localparam logic [OUTC_W-1:0] OUTC_IN_SEG     = 2'd0;
    localparam logic [OUTC_W-1:0] OUTC_EMPTY      = 2'd1;
    localparam logic [OUTC_W-1:0] OUTC_ZERO_CYCLE = 2'd2;
    localparam logic [OUTC_W-1:0] OUTC_NO_MATCH   = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y    = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic [SLOT_W-1:0]        key_slot;
        logic [TIME_W-1:0]        key_time;
        logic signed [OFF_W-1:0]  key_dx;
        logic signed [OFF_W-1:0]  key_dy;
        logic [QTIME_W-1:0]       query_time;
    } t_in_item;

    typedef struct packed {
        logic signed [OFF_W-1:0]  pos_x;
        logic signed [OFF_W-1:0]  pos_y;
        logic [SEG_W-1:0]         segment;
        logic [OUTC_W-1:0]        outcome;
    } t_out_item;

    typedef struct packed {
        logic [TIME_W-1:0]        ktime;
        logic signed [OFF_W-1:0]  dx;
        logic signed [OFF_W-1:0]  dy;
    } t_key;

endpackage

`default_nettype wire

>>> rtl/core/looping_keyframe_interpolator.sv
// Channel  Direction  Handshake                   Payload
// in       slave      i_in_valid / o_in_ready     i_in_data  (load or query item)
// out      master     o_out_valid / i_out_ready   o_out_data (one result per query)
// cfg      slave      i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// A query runs the 36-step shared divider, used once for the time wrap and once per
// axis, and searches the key table for its segment.
// Reset is synchronous and active low; it clears the sequencer, the output valid
// and the configuration registers. The key table is not cleared.
// While the output register is still full the finished result waits in place and
// no new item is taken; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module looping_keyframe_interpolator (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  lki_pkg::t_in_item            i_in_data,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output lki_pkg::t_out_item           o_out_data,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire [lki_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire [lki_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import lki_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CYC_RD, S_CYC, S_MOD, S_T0_RD, S_T0, S_SCAN, S_SCAN_RD,
        S_KEY_RD, S_KEY, S_MUL, S_LOAD, S_DIV, S_ACC, S_FINISH
    } t_state;

    t_state                   r_state;
    logic [KCFG_W-1:0]        r_key_count;
    logic signed [OFF_W-1:0]  r_base_x;
    logic signed [OFF_W-1:0]  r_base_y;

    t_key                     r_mem [MAX_KEYS];
    t_key                     r_rd;
    logic [IDX_W-1:0]         r_raddr;

    logic [KCNT_W-1:0]        r_n;
    logic [IDX_W-1:0]         r_idx;
    logic [TIME_W-1:0]        r_s;
    t_key                     r_prev;
    t_key                     r_cur;
    logic [TIME_W-1:0]        r_d;
    logic                     r_axis;
    logic signed [PROD_W-1:0] r_prod;
    logic                     r_neg;
    logic [DIV_W-1:0]         r_num;
    logic [DVS_W-1:0]         r_rem;
    logic [DVS_W-1:0]         r_dvs;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [OFF_W-1:0]  r_ox;
    logic signed [OFF_W-1:0]  r_oy;
    logic [IDX_W-1:0]         r_seg;
    logic [OUTC_W-1:0]        r_outcome;
    logic                     r_out_valid;
    t_out_item                r_out;

    logic                     w_in_acc;
    logic [KCNT_W-1:0]        w_n;
    logic [DVS_W:0]           w_trial;
    logic [DVS_W:0]           w_diffr;
    logic                     w_ge;
    logic [DVS_W-1:0]         n_rem;
    logic [DIV_W-1:0]         n_num;
    logic                     w_hit;
    logic [TIME_W-1:0]        w_dt;
    logic [KCNT_W:0]          w_idx2;
    logic                     w_last;
    logic signed [OFF_W-1:0]  w_a;
    logic signed [OFF_W-1:0]  w_b;
    logic signed [OFF_W:0]    w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0]        w_mag;
    logic [QUO_W:0]           w_q;
    logic signed [QUO_W:0]    w_off;
    logic                     w_out_free;

    function automatic logic signed [OFF_W-1:0] sat_add(
        input logic signed [OFF_W-1:0] a,
        input logic signed [OFF_W-1:0] b
    );
        logic signed [OFF_W:0] sum;
        sum = {a[OFF_W-1], a} + {b[OFF_W-1], b};
        if (sum[OFF_W] != sum[OFF_W-1]) begin
            sat_add = sum[OFF_W] ? {1'b1, {(OFF_W-1){1'b0}}} : {1'b0, {(OFF_W-1){1'b1}}};
        end else begin
            sat_add = sum[OFF_W-1:0];
        end
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_n = (32'(r_key_count) > MAX_KEYS) ? KCNT_W'(MAX_KEYS) : KCNT_W'(r_key_count);

    // One restoring division step: a bit of quotient per cycle.
    assign w_trial = {r_rem, r_num[DIV_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});
    assign w_diffr = w_trial - {1'b0, r_dvs};
    assign n_rem   = w_ge ? w_diffr[DVS_W-1:0] : w_trial[DVS_W-1:0];
    assign n_num   = {r_num[DIV_W-2:0], w_ge};

    // Segment search compares the wrapped time against keys idx and idx + 1.
    assign w_hit  = (r_s >= r_prev.ktime) && (r_s <= r_rd.ktime);
    assign w_dt   = r_rd.ktime - r_prev.ktime;
    assign w_idx2 = (KCNT_W + 1)'(r_idx) + (KCNT_W + 1)'(2);
    assign w_last = (w_idx2 == (KCNT_W + 1)'(r_n));

    assign w_a    = r_axis ? r_prev.dy : r_prev.dx;
    assign w_b    = r_axis ? r_cur.dy : r_cur.dx;
    assign w_diff = {w_b[OFF_W-1], w_b} - {w_a[OFF_W-1], w_a};
    assign w_prod = $signed({1'b0, r_d}) * w_diff;
    assign w_mag  = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    // The quotient never exceeds the endpoint difference, so QUO_W bits hold it.
    assign w_q   = {1'b0, r_num[QUO_W-1:0]};
    assign w_off = {{2{w_a[OFF_W-1]}}, w_a} + (r_neg ? -w_q : w_q);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= '0;
            r_base_x    <= '0;
            r_base_y    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_KEY_COUNT: r_key_count <= i_cfg_data[KCFG_W-1:0];
                CFG_BASE_X:    r_base_x    <= i_cfg_data;
                CFG_BASE_Y:    r_base_y    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (i_in_data.mode == MODE_LOAD) &&
                (32'(i_in_data.key_slot) < MAX_KEYS)) begin
            r_mem[IDX_W'(i_in_data.key_slot)] <= '{ktime: i_in_data.key_time,
                                                  dx: i_in_data.key_dx,
                                                  dy: i_in_data.key_dy};
        end
        r_rd <= r_mem[r_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // A finishing query reloads the output register itself.
            if (r_out_valid && i_out_ready && (r_state != S_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (i_in_data.mode == MODE_QUERY)) begin
                        r_num <= DIV_W'(i_in_data.query_time);
                        r_n   <= w_n;
                        if (w_n == '0) begin
                            r_ox      <= '0;
                            r_oy      <= '0;
                            r_seg     <= '0;
                            r_outcome <= OUTC_EMPTY;
                            r_state   <= S_FINISH;
                        end else begin
                            r_raddr <= IDX_W'(w_n - KCNT_W'(1));
                            r_state <= S_CYC_RD;
                        end
                    end
                end
                S_CYC_RD: r_state <= S_CYC;
                S_CYC: begin
                    r_seg <= '0;
                    if (r_rd.ktime == '0) begin
                        r_outcome <= OUTC_ZERO_CYCLE;
                        r_raddr   <= '0;
                        r_state   <= S_KEY_RD;
                    end else begin
                        r_dvs   <= r_rd.ktime;
                        r_rem   <= '0;
                        r_cnt   <= CNT_W'(DIV_W - 1);
                        r_state <= S_MOD;
                    end
                end
                S_MOD: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_raddr <= '0;
                        r_state <= S_T0_RD;
                    end
                end
                S_T0_RD: begin
                    r_s     <= r_rem;
                    r_raddr <= IDX_W'(1);
                    r_state <= S_T0;
                end
                S_T0: begin
                    r_prev <= r_rd;
                    r_idx  <= '0;
                    if (r_n == KCNT_W'(1)) begin
                        r_outcome <= OUTC_NO_MATCH;
                        r_raddr   <= '0;
                        r_state   <= S_KEY_RD;
                    end else begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_hit) begin
                        r_seg     <= r_idx;
                        r_outcome <= OUTC_IN_SEG;
                        if (w_dt == '0) begin
                            r_ox    <= r_prev.dx;
                            r_oy    <= r_prev.dy;
                            r_state <= S_FINISH;
                        end else begin
                            r_cur   <= r_rd;
                            r_d     <= r_s - r_prev.ktime;
                            r_dvs   <= w_dt;
                            r_axis  <= 1'b0;
                            r_state <= S_MUL;
                        end
                    end else if (w_last) begin
                        r_seg     <= '0;
                        r_outcome <= OUTC_NO_MATCH;
                        r_raddr   <= IDX_W'(r_n - KCNT_W'(1));
                        r_state   <= S_KEY_RD;
                    end else begin
                        r_prev  <= r_rd;
                        r_idx   <= r_idx + IDX_W'(1);
                        r_raddr <= IDX_W'(w_idx2);
                        r_state <= S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN;
                S_KEY_RD:  r_state <= S_KEY;
                S_KEY: begin
                    r_ox    <= r_rd.dx;
                    r_oy    <= r_rd.dy;
                    r_state <= S_FINISH;
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_num   <= w_mag[DIV_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= CNT_W'(DIV_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    r_cnt <= r_cnt - CNT_W'(1);
                    if (r_cnt == '0) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (!r_axis) begin
                        r_ox    <= w_off[OFF_W-1:0];
                        r_axis  <= 1'b1;
                        r_state <= S_MUL;
                    end else begin
                        r_oy    <= w_off[OFF_W-1:0];
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out.pos_x   <= sat_add(r_base_x, r_ox);
                        r_out.pos_y   <= sat_add(r_base_y, r_oy);
                        r_out.segment <= SEG_W'(r_seg);
                        r_out.outcome <= r_outcome;
                        r_out_valid   <= 1'b1;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    // The partial remainder stays below the divisor during every division.
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD || r_state == S_DIV) |-> (r_rem < r_dvs))
        else $error("divider remainder not below divisor");

    // The search never compares past the last valid key.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (w_idx2 <= (KCNT_W + 1)'(r_n)))
        else $error("segment search beyond key count");

    // An interpolation quotient fits in QUO_W bits.
    a_quotient_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC) |-> (r_num[DIV_W-1:QUO_W] == '0))
        else $error("interpolation quotient too wide");

    // A finished result with a free output register is shown in the next cycle.
    a_finish_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished result not delivered");
`endif

endmodule

`default_nettype wire
